[hdl/isra_pkg.sv]
// Shared widths, register indexes and limits of the scaled residual adder.
package isra_pkg;

   localparam int ELEM_W  = 8;
   localparam int MULT_W  = 25;
   localparam int SHIFT_W = 5;
   localparam int PROD_W  = ELEM_W + MULT_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int CSR_IDX_W = 3;

   localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_MULT    = 3'd0,
      CSR_B_MULT    = 3'd1,
      CSR_SHIFT     = 3'd2,
      CSR_CLAMP_LOW = 3'd3,
      CSR_CLAMP_HI  = 3'd4
   } csr_index_type;

   localparam logic signed [MULT_W-1:0] A_MULT_RESET    = 25'sd4194304;
   localparam logic signed [MULT_W-1:0] B_MULT_RESET    = 25'sd4194304;
   localparam logic [SHIFT_W-1:0]       SHIFT_RESET     = 5'd22;
   localparam logic signed [ELEM_W-1:0] CLAMP_LOW_RESET = -8'sd128;
   localparam logic signed [ELEM_W-1:0] CLAMP_HI_RESET  = 8'sd127;

endpackage

[hdl/int8_scaled_residual_add_top.sv]
// Scaled residual add of two int8 streams: multiply, add, rounding shift, clamp.
//
// Each word carries one pair of int8 elements. Each element is multiplied by its own
// signed 25-bit multiplier, the products are summed, shifted right by shift_amount
// (saturated at 24) rounding half away from zero, then clamped to [clamp_low,
// clamp_high]. One word per cycle is taken unless the output stalls, and one result
// per word comes out, through a five-stage pipeline: multiply, add, round, shift,
// clamp. Each stage stalls only when it is full and the next cannot take its word.
// Write the registers only while the pipeline is empty.
module int8_scaled_residual_add_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // a_value [7:0], b_value [15:8]
   input  logic                           req_tlast,   // last_in
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // sum_value [7:0]
   output logic                           rsp_tlast,   // last_out
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [isra_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [isra_pkg::MULT_W-1:0]    csr_data
);
   import isra_pkg::*;

   logic signed [MULT_W-1:0]  a_mult_ff;
   logic signed [MULT_W-1:0]  b_mult_ff;
   logic [SHIFT_W-1:0]        shift_ff;
   logic signed [ELEM_W-1:0]  clamp_low_ff;
   logic signed [ELEM_W-1:0]  clamp_hi_ff;

   logic [SHIFT_W-1:0]        shift_sat;
   logic [PROD_W-1:0]         rnd_const;

   logic                      vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   logic                      rdy1, rdy2, rdy3, rdy4, rdy5;
   logic                      last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;

   logic signed [ELEM_W-1:0]  a_val;
   logic signed [ELEM_W-1:0]  b_val;
   logic signed [PROD_W-1:0]  prod_a_in, prod_b_in;
   logic signed [PROD_W-1:0]  prod_a_ff, prod_b_ff;
   logic signed [ACC_W-1:0]   acc_in, acc_ff;
   logic signed [ACC_W:0]     acc_ext, rnd_ext, round_sum;
   logic [PROD_W-1:0]         round_in, round_ff;
   logic                      neg_ff;
   logic [PROD_W-1:0]         shifted;
   logic signed [ACC_W-1:0]   mag_ext, val_in, val_ff;
   logic signed [ACC_W-1:0]   lo_ext, hi_ext, lo_cl;
   logic [ELEM_W-1:0]         sum_in, sum_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_mult_ff    <= A_MULT_RESET;
         b_mult_ff    <= B_MULT_RESET;
         shift_ff     <= SHIFT_RESET;
         clamp_low_ff <= CLAMP_LOW_RESET;
         clamp_hi_ff  <= CLAMP_HI_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_A_MULT:    a_mult_ff    <= csr_data;
            CSR_B_MULT:    b_mult_ff    <= csr_data;
            CSR_SHIFT:     shift_ff     <= csr_data[SHIFT_W-1:0];
            CSR_CLAMP_LOW: clamp_low_ff <= csr_data[ELEM_W-1:0];
            CSR_CLAMP_HI:  clamp_hi_ff  <= csr_data[ELEM_W-1:0];
            default: ;
         endcase
      end
   end

   assign shift_sat = (shift_ff > MAX_SHIFT) ? MAX_SHIFT : shift_ff;
   assign rnd_const = (shift_sat == '0) ? '0
                                        : (PROD_W'(1) << (shift_sat - SHIFT_W'(1)));

   assign rdy5       = !vld5_ff || rsp_tready;
   assign rdy4       = !vld4_ff || rdy5;
   assign rdy3       = !vld3_ff || rdy4;
   assign rdy2       = !vld2_ff || rdy3;
   assign rdy1       = !vld1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= req_tvalid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
         if (rdy4) vld4_ff <= vld3_ff;
         if (rdy5) vld5_ff <= vld4_ff;
      end
   end

   assign a_val     = req_tdata[ELEM_W-1:0];
   assign b_val     = req_tdata[2*ELEM_W-1:ELEM_W];
   assign prod_a_in = $signed({{MULT_W{a_val[ELEM_W-1]}}, a_val})
                    * $signed({{ELEM_W{a_mult_ff[MULT_W-1]}}, a_mult_ff});
   assign prod_b_in = $signed({{MULT_W{b_val[ELEM_W-1]}}, b_val})
                    * $signed({{ELEM_W{b_mult_ff[MULT_W-1]}}, b_mult_ff});

   assign acc_in    = {prod_a_ff[PROD_W-1], prod_a_ff} + {prod_b_ff[PROD_W-1], prod_b_ff};

   assign acc_ext   = {acc_ff[ACC_W-1], acc_ff};
   assign rnd_ext   = {2'b00, rnd_const};
   assign round_sum = acc_ff[ACC_W-1] ? (rnd_ext - acc_ext) : (acc_ext + rnd_ext);
   assign round_in  = round_sum[PROD_W-1:0];

   assign shifted   = round_ff >> shift_sat;
   assign mag_ext   = {1'b0, shifted};
   assign val_in    = neg_ff ? -mag_ext : mag_ext;

   assign lo_ext    = {{(ACC_W-ELEM_W){clamp_low_ff[ELEM_W-1]}}, clamp_low_ff};
   assign hi_ext    = {{(ACC_W-ELEM_W){clamp_hi_ff[ELEM_W-1]}}, clamp_hi_ff};
   assign lo_cl     = (val_ff < lo_ext) ? lo_ext : val_ff;
   assign sum_in    = (lo_cl > hi_ext) ? clamp_hi_ff : lo_cl[ELEM_W-1:0];

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         last1_ff  <= req_tlast;
      end
      if (rdy2) begin
         acc_ff   <= acc_in;
         last2_ff <= last1_ff;
      end
      if (rdy3) begin
         round_ff <= round_in;
         neg_ff   <= acc_ff[ACC_W-1];
         last3_ff <= last2_ff;
      end
      if (rdy4) begin
         val_ff   <= val_in;
         last4_ff <= last3_ff;
      end
      if (rdy5) begin
         sum_ff   <= sum_in;
         last5_ff <= last4_ff;
      end
   end

   assign rsp_tvalid = vld5_ff;
   assign rsp_tdata  = sum_ff;
   assign rsp_tlast  = last5_ff;

endmodule
